/* src/itd_pkg.sv */
// Shared constants for the integer to decimal ASCII converter.
package itd_pkg;

  // Input value width and the number of decimal digits it can need
  localparam int unsigned ValueWidth = 31;
  localparam int unsigned ValDigits  = 10;

  // One decimal digit and one output character
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned CharWidth  = 6;

  // Upper bits of an ASCII digit: '0' is 6'b11_0000 within a 6-bit code
  localparam logic [CharWidth-DigitWidth-1:0] AsciiDigitHi = 2'b11;

  // Divide by ten: q = (v * Recip10) >> Recip10Shift, exact for any 32-bit v
  localparam int unsigned RecipWidth   = 32;
  localparam logic [RecipWidth-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;
  localparam int unsigned ProdWidth    = ValueWidth + RecipWidth;

endpackage

/* src/itd_cell.sv */
// One conversion cell: splits off the lowest decimal digit of the quotient it receives.
module itd_cell #(
  parameter int unsigned NumDigits = 10,
  parameter int unsigned CntWidth  = 4
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  // upstream side
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic [itd_pkg::ValueWidth-1:0]                    in_quot_i,
  input  logic [NumDigits-1:0][itd_pkg::DigitWidth-1:0]     in_digits_i,
  input  logic [CntWidth-1:0]                               in_count_i,
  // downstream side
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [itd_pkg::ValueWidth-1:0]                    out_quot_o,
  output logic [NumDigits-1:0][itd_pkg::DigitWidth-1:0]     out_digits_o,
  output logic [CntWidth-1:0]                               out_count_o
);

  logic [itd_pkg::ProdWidth-1:0]                prod;
  logic [itd_pkg::ValueWidth-1:0]               quot_d;
  logic [itd_pkg::ValueWidth-1:0]               quot_x10;
  logic [itd_pkg::ValueWidth-1:0]               rem_full;
  logic [itd_pkg::DigitWidth-1:0]               rem;
  logic [NumDigits-1:0][itd_pkg::DigitWidth-1:0] digits_d;
  logic [CntWidth-1:0]                          count_d;
  logic                                         valid_d, valid_q;
  logic                                         load;
  logic [itd_pkg::ValueWidth-1:0]               quot_q;
  logic [NumDigits-1:0][itd_pkg::DigitWidth-1:0] digits_q;
  logic [CntWidth-1:0]                          count_q;

  // divide by ten through the reciprocal, remainder by shift-add back-multiply
  assign prod     = {{itd_pkg::RecipWidth{1'b0}}, in_quot_i}
                  * {{itd_pkg::ValueWidth{1'b0}}, itd_pkg::Recip10};
  assign quot_d   = itd_pkg::ValueWidth'(prod[itd_pkg::ProdWidth-1:itd_pkg::Recip10Shift]);
  assign quot_x10 = (quot_d << 3) + (quot_d << 1);
  assign rem_full = in_quot_i - quot_x10;
  assign rem      = rem_full[itd_pkg::DigitWidth-1:0];

  // new digit enters at the top; the first digit found ends up at index 0
  if (NumDigits > 1) begin : g_shift
    assign digits_d = {rem, in_digits_i[NumDigits-1:1]};
  end else begin : g_single
    assign digits_d = rem;
  end

  // a digit counts if it is the first one or the value is still nonzero
  always_comb begin
    if ((in_quot_i != '0) || (in_count_i == '0)) begin
      count_d = in_count_i + CntWidth'(1);
    end else begin
      count_d = in_count_i;
    end
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quot_q   <= quot_d;
      digits_q <= digits_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_quot_o   = quot_q;
  assign out_digits_o = digits_q;
  assign out_count_o  = count_q;

endmodule

/* src/itd_emit.sv */
// Output serializer: sends the digits of one value most significant first.
module itd_emit #(
  parameter int unsigned NumDigits = 10,
  parameter int unsigned CntWidth  = 4
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // from the last cell
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [NumDigits-1:0][itd_pkg::DigitWidth-1:0] in_digits_i,
  input  logic [CntWidth-1:0]                           in_count_i,
  // result channel
  output logic                                          valid_o,
  input  logic                                          stall_i,
  output logic [itd_pkg::CharWidth-1:0]                 digit_char_o,
  output logic                                          last_o
);

  localparam int unsigned IdxWidth = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  logic                                          busy_d, busy_q;
  logic [NumDigits-1:0][itd_pkg::DigitWidth-1:0] digits_q;
  logic [IdxWidth-1:0]                           idx_q;
  logic [CntWidth-1:0]                           start_idx;
  logic                                          fire;
  logic                                          done;
  logic                                          load;

  // a request leaves when not stalled; the final digit frees the buffer
  assign fire       = busy_q && !stall_i;
  assign done       = fire && (idx_q == '0);
  assign in_ready_o = !busy_q || done;
  assign load       = in_valid_i && in_ready_o;
  assign busy_d     = in_ready_o ? in_valid_i : busy_q;
  assign start_idx  = in_count_i - CntWidth'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // digit buffer and read pointer, counting down to the least significant digit
  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= in_digits_i;
      idx_q    <= IdxWidth'(start_idx);
    end else if (fire) begin
      idx_q    <= idx_q - IdxWidth'(1);
    end
  end

  assign valid_o      = busy_q;
  assign digit_char_o = {itd_pkg::AsciiDigitHi, digits_q[idx_q]};
  assign last_o       = (idx_q == '0);

endmodule

/* src/integer_to_decimal_ascii_top.sv */
// Top level of the binary to decimal ASCII converter.
// Converts a 31-bit unsigned value to decimal ASCII text, one character per
// result request, most significant digit first, leading zeros suppressed
// (zero gives a single '0'), with last_o set on the least significant digit.
// Only the MAX_DIGITS lowest digits are sent (MAX_DIGITS of zero acts as one).
// A chain of min(MAX_DIGITS, 10) registered cells each peel off one digit, and
// new values are taken every cycle while the chain moves. The output side sends
// one character per cycle while stall_i is low, and takes the next value from
// the chain as the last character of the current one is sent.
module integer_to_decimal_ascii_top #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [itd_pkg::ValueWidth-1:0]    value_i,
  // result channel
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [itd_pkg::CharWidth-1:0]     digit_char_o,
  output logic                              last_o
);

  localparam int unsigned NumCells = (MAX_DIGITS < 1) ? 1 :
                                     (MAX_DIGITS < itd_pkg::ValDigits) ?
                                     MAX_DIGITS : itd_pkg::ValDigits;
  localparam int unsigned CntWidth = $clog2(NumCells + 1);

  logic [NumCells:0]                                        vld;
  logic [NumCells:0]                                        rdy;
  logic [NumCells:0][itd_pkg::ValueWidth-1:0]               quot;
  logic [NumCells:0][NumCells-1:0][itd_pkg::DigitWidth-1:0] digs;
  logic [NumCells:0][CntWidth-1:0]                          cnt;

  // head of the chain takes the request straight from the ports
  assign vld[0]  = valid_i;
  assign stall_o = !rdy[0];
  assign quot[0] = value_i;
  assign digs[0] = '0;
  assign cnt[0]  = '0;

  // digit cells, lowest digit first
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    itd_cell #(
      .NumDigits (NumCells),
      .CntWidth  (CntWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .in_valid_i   (vld[k]),
      .in_ready_o   (rdy[k]),
      .in_quot_i    (quot[k]),
      .in_digits_i  (digs[k]),
      .in_count_i   (cnt[k]),
      .out_valid_o  (vld[k+1]),
      .out_ready_i  (rdy[k+1]),
      .out_quot_o   (quot[k+1]),
      .out_digits_o (digs[k+1]),
      .out_count_o  (cnt[k+1])
    );
  end

  // serializer at the tail of the chain
  itd_emit #(
    .NumDigits (NumCells),
    .CntWidth  (CntWidth)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (vld[NumCells]),
    .in_ready_o   (rdy[NumCells]),
    .in_digits_i  (digs[NumCells]),
    .in_count_i   (cnt[NumCells]),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

/* verif/decimal_text_checker.sv */
// Checker for the decimal ASCII converter: predicts the digit text and compares results.
module decimal_text_checker #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel as seen at the block
  input  logic                            req_valid_i,
  input  logic                            req_stall_i,
  input  logic [itd_pkg::ValueWidth-1:0]  value_i,
  // result channel as seen at the block
  input  logic                            res_valid_i,
  input  logic                            res_stall_i,
  input  logic [itd_pkg::CharWidth-1:0]   digit_char_i,
  input  logic                            last_i,
  // totals for the top
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o,
  output int unsigned                     values_o,
  output int unsigned                     chars_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AsciiZero   = 48;
  localparam int unsigned DigitBase   = 10;
  localparam int unsigned DigitBufLen = 20;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [itd_pkg::CharWidth-1:0] code;
    logic                          last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t  expected_text[$];
  int unsigned fail_cnt    = 0;
  int unsigned pending_cnt = 0;
  int unsigned value_cnt   = 0;
  int unsigned char_cnt    = 0;

  assign mismatches_o = fail_cnt;
  assign pending_o    = pending_cnt;
  assign values_o     = value_cnt;
  assign chars_o      = char_cnt;

  // Number of low digits kept; the buffer bounds it to 1..20
  function automatic int digit_keep();
    int keep;
    keep = MAX_DIGITS;
    if (keep < 1) keep = 1;
    if (keep > DigitBufLen) keep = DigitBufLen;
    return keep;
  endfunction

  // Peel decimal digits off the value and queue them most significant first
  function automatic void queue_decimal_text(logic [itd_pkg::ValueWidth-1:0] value);
    logic [itd_pkg::DigitWidth-1:0] digs [DigitBufLen];
    longint unsigned                rest;
    int                             count;
    text_char_t                     c;
    rest  = value;
    count = 0;
    do begin
      digs[count] = itd_pkg::DigitWidth'(rest % DigitBase);
      rest        = rest / DigitBase;
      count++;
    end while (rest != 0 && count < DigitBufLen);
    if (count > digit_keep()) count = digit_keep();
    for (int k = count - 1; k >= 0; k--) begin
      c.code = itd_pkg::CharWidth'(AsciiZero + digs[k]);
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  function automatic void note_mismatch(string what);
    fail_cnt++;
    if (fail_cnt <= ReportLimit) $display("%0t ns: %s", $realtime, what);
  endfunction

  // Requests feed the prediction; each result is held against the oldest character
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (req_valid_i && !req_stall_i) begin
        queue_decimal_text(value_i);
        value_cnt++;
      end
      if (res_valid_i && !res_stall_i) begin
        char_cnt++;
        if (expected_text.size() == 0) begin
          note_mismatch($sformatf("unexpected result: char %0d last %0b, nothing pending",
                                  digit_char_i, last_i));
        end else begin
          want = expected_text.pop_front();
          if (digit_char_i !== want.code || last_i !== want.last)
            note_mismatch($sformatf("result %0d: expected char %0d last %0b, got char %0d last %0b",
                                    char_cnt, want.code, want.last, digit_char_i, last_i));
        end
      end
      pending_cnt = expected_text.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the testbench for the decimal ASCII converter: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDigits    = 10;
  localparam int unsigned RandomValues = 400;
  localparam int unsigned PaceBlock    = 50;
  localparam int unsigned CornerCount  = 25;

  // how busy both sides are during a stretch of the run
  typedef enum logic [1:0] {
    PaceSteady,
    PaceMixed,
    PaceChoked
  } pace_e;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic [itd_pkg::ValueWidth-1:0] in_value  = '0;
  logic                           out_stall = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [itd_pkg::CharWidth-1:0]  digit_char;
  logic                           res_last;
  pace_e                          pace      = PaceMixed;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned values_seen;
  int unsigned chars_seen;

  // zero, digit-count boundaries, the full range and mixed bit patterns
  logic [itd_pkg::ValueWidth-1:0] corner_vals [CornerCount] = '{
    31'd0, 31'd1, 31'd7, 31'd9, 31'd10, 31'd11, 31'd20, 31'd42, 31'd99, 31'd100,
    31'd999, 31'd1000, 31'd99999, 31'd100000, 31'd999999999, 31'd1000000000,
    31'd1234567890, 31'd1999999999, 31'd2000000000, 31'd1073741823,
    31'd1073741824, 31'd2147483646, 31'd2147483647, 31'h2AAA_AAAA, 31'h5555_5555
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  integer_to_decimal_ascii_top #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .valid_i     (in_valid),
    .stall_o     (in_stall),
    .value_i     (in_value),
    .valid_o     (out_valid),
    .stall_i     (out_stall),
    .digit_char_o(digit_char),
    .last_o      (res_last)
  );

  decimal_text_checker #(
    .MAX_DIGITS(MaxDigits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (in_valid),
    .req_stall_i (in_stall),
    .value_i     (in_value),
    .res_valid_i (out_valid),
    .res_stall_i (out_stall),
    .digit_char_i(digit_char),
    .last_i      (res_last),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .values_o    (values_seen),
    .chars_o     (chars_seen)
  );

  // Gap length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len(pace_e p);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (p == PaceSteady) return 0;
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Mostly a value of a random digit count, some at the count's edges, some raw bits
  function automatic logic [itd_pkg::ValueWidth-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     ndig;
    int unsigned     pick;
    pick = $urandom_range(0, 9);
    ndig = $urandom_range(1, itd_pkg::ValDigits);
    lo   = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi   = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
    if (pick < 3) return itd_pkg::ValueWidth'($urandom);
    if (pick == 3) return itd_pkg::ValueWidth'(($urandom_range(0, 1) != 0) ? lo : hi);
    return itd_pkg::ValueWidth'(lo + $urandom_range(0, 32'(hi - lo)));
  endfunction

  // Drive one request after an optional gap; returns at the edge that takes it
  task automatic send_value(input logic [itd_pkg::ValueWidth-1:0] v, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Result side back-pressure: runs of stall and free cycles
  int unsigned stall_hold = 0;
  always @(posedge clk) begin
    if (pace == PaceSteady) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold == 0) begin
      out_stall <= (pace == PaceChoked) ? ($urandom_range(0, 3) != 0)
                                        : ($urandom_range(0, 2) == 0);
      stall_hold = idle_len(pace);
    end else begin
      stall_hold--;
    end
  end

  // Run limit, well above the slowest correct run
  initial begin
    #1_500_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_vals[i]) send_value(corner_vals[i], idle_len(pace));

    for (int unsigned n = 0; n < RandomValues; n++) begin
      if (n % PaceBlock == 0) pace <= pace_e'($urandom_range(0, 2));
      send_value(random_value(), idle_len(pace));
    end
    in_valid <= 1'b0;
    pace     <= PaceSteady;

    // let the text drain, then watch for stray characters
    while (pending != 0) @(posedge clk);
    repeat (MaxDigits + 20) @(posedge clk);

    $display("Converted %0d values (%0d corner cases, %0d random) into %0d digit characters",
             values_seen, CornerCount, values_seen - CornerCount, chars_seen);
    $display("Gaps and back-pressure varied across steady, mixed and heavy stretches");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
src/itd_pkg.sv
src/itd_cell.sv
src/itd_emit.sv
src/integer_to_decimal_ascii_top.sv
verif/decimal_text_checker.sv
verif/testbench.sv
